FILE: src/vphd_pkg.sv
// shared types and constants of the valve peak-and-hold driver
`default_nettype none

package vphd_pkg;

    localparam int ZONES  = 6;
    localparam int ZONE_W = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CNT_W  = $clog2(ZONES + 1);

    localparam logic [7:0]  FULL_DUTY  = 8'd255;
    localparam logic [15:0] PULL_RESET = 16'd200;
    localparam logic [6:0]  HOLD_RESET = 7'd50;

    // divide by 100 as multiply by ceil(2^22 / 100) then shift by 22
    localparam logic [15:0] HOLD_RECIP = 16'd41944;
    localparam int          HOLD_SHIFT = 22;

    // configuration register indexes
    localparam logic CFG_PULL_IN = 1'b0;
    localparam logic CFG_HOLD    = 1'b1;

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZONE,
        ST_CLEAR,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef logic [ZONE_W-1:0] t_zidx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [2:0]        t_chan;

    // one entry of the zone state memory
    typedef struct packed {
        logic        open;
        logic [31:0] stamp;
    } t_entry;

    // one result word
    typedef struct packed {
        logic       strobe;
        logic       ok;
        logic       zone_open;
        logic       write_valid;
        t_chan      channel;
        logic [7:0] duty;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

FILE: src/vphd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module vphd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/vphd_hold.sv
// hold duty scaler: hold_percent * 255 / 100, saturated at full duty
`default_nettype none

module vphd_hold
    import vphd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic [6:0] i_hold_pct,
    output logic      [7:0] o_hold_duty
);

    logic [14:0] w_scaled;
    logic [30:0] w_prod;
    logic [8:0]  w_quot;
    logic [7:0]  r_duty;

    // p * 255 as p * 256 - p
    assign w_scaled = {i_hold_pct, 8'b0} - {8'b0, i_hold_pct};
    assign w_prod   = {16'b0, w_scaled} * {15'b0, HOLD_RECIP};
    assign w_quot   = w_prod[HOLD_SHIFT +: 9];

    // one register stage: a new percentage shows up the cycle after it is written
    always_ff @(posedge i_clk) begin
        r_duty <= w_quot[8] ? FULL_DUTY : w_quot[7:0];
    end

    assign o_hold_duty = r_duty;

endmodule

`default_nettype wire

FILE: src/valve_peak_hold_driver.sv
// top level of the valve peak-and-hold driver: command sequencer around the zone state ram
//
//  port group   direction  handshake                payload
//  command      in         start & !busy            i_mode, i_zone_id, i_open_request,
//                                                   i_now_ms
//  result       out        o_strobe, one cycle      o_ok, o_zone_open, o_write_valid,
//                          no stall                 o_channel, o_duty, o_last
//  config       in         i_cfg_we                 i_cfg_idx, i_cfg_data
//
//  set or query of a valid zone: ram read, then the result; a set that changes the zone writes back
//  set or query of an invalid zone: result the next cycle, busy stays low
//  close all: one zero-duty word per zone; tick: a scan of every zone, then a flush word
//  the single read port of the state ram, one zone per cycle, sets the walk length
//  reset clears per-zone valid bits at once, an unwritten zone reads as closed
//  the receiver cannot stall: every result word is shown for exactly one cycle
`default_nettype none

module valve_peak_hold_driver
    import vphd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [3:0]  i_zone_id,
    input  wire logic        i_open_request,
    input  wire logic [31:0] i_now_ms,
    // result
    output logic             o_strobe,
    output logic             o_ok,
    output logic             o_zone_open,
    output logic             o_write_valid,
    output logic [2:0]       o_channel,
    output logic [7:0]       o_duty,
    output logic             o_last,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_pull_in;
    logic [6:0]  r_hold_pct;
    logic [7:0]  w_hold_duty;

    // sequencer state
    t_state      r_state, n_state;
    t_cnt        r_cnt, n_cnt;
    t_zidx       r_evidx, n_evidx;
    logic        r_pend, n_pend;
    t_zidx       r_pidx, n_pidx;
    logic [ZONES-1:0] r_valid, n_valid;
    t_result     r_res, n_res;

    // latched command word
    t_mode       r_mode;
    t_zidx       r_idx;
    logic        r_req;
    logic [31:0] r_now;

    // ram port
    logic        w_we;
    t_zidx       w_waddr;
    t_entry      w_wdata;
    t_zidx       w_raddr;
    t_entry      w_rdata;

    // decode of the incoming command
    logic        w_accept;
    logic        w_in_valid;
    t_zidx       w_in_idx;
    logic        w_cur_open;
    logic        w_due;
    logic [31:0] w_elapsed;

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_in_valid = (i_zone_id != 4'd0) && (i_zone_id <= 4'(ZONES));
    assign w_in_idx   = t_zidx'(i_zone_id - 4'd1);

    // a zone never written since reset or close-all reads as closed
    assign w_cur_open = r_valid[r_idx] && w_rdata.open;
    assign w_elapsed  = r_now - w_rdata.stamp;
    assign w_due      = r_valid[r_evidx] && w_rdata.open && (w_elapsed >= {16'b0, r_pull_in});

    vphd_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ZONES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vphd_hold u_hold (
        .i_clk       (i_clk),
        .i_hold_pct  (r_hold_pct),
        .o_hold_duty (w_hold_duty)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pull_in  <= PULL_RESET;
            r_hold_pct <= HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PULL_IN: r_pull_in  <= i_cfg_data;
                CFG_HOLD:    r_hold_pct <= i_cfg_data[6:0];
                default:     r_pull_in  <= r_pull_in;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_evidx <= '0;
            r_pend  <= 1'b0;
            r_pidx  <= '0;
            r_valid <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_evidx <= n_evidx;
            r_pend  <= n_pend;
            r_pidx  <= n_pidx;
            r_valid <= n_valid;
            r_res   <= n_res;
        end
    end

    // command word latch, payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_mode);
            r_idx  <= w_in_idx;
            r_req  <= i_open_request;
            r_now  <= i_now_ms;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_evidx = r_evidx;
        n_pend  = r_pend;
        n_pidx  = r_pidx;
        n_valid = r_valid;
        n_res   = '0;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        w_raddr = r_cnt[ZONE_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode) inside
                        MODE_SET, MODE_QUERY: begin
                            if (w_in_valid) begin
                                w_raddr = w_in_idx;
                                n_state = ST_ZONE;
                            end else begin
                                // bad zone id: answer at once, no state change
                                n_res.strobe = 1'b1;
                                n_res.last   = 1'b1;
                            end
                        end
                        MODE_CLOSE: begin
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        MODE_TICK: begin
                            // read zone 0 now, evaluate it next cycle
                            w_raddr = '0;
                            n_cnt   = t_cnt'(1);
                            n_evidx = '0;
                            n_pend  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            ST_ZONE: begin
                n_res.strobe = 1'b1;
                n_res.ok     = 1'b1;
                n_res.last   = 1'b1;
                if (r_mode == MODE_QUERY) begin
                    n_res.zone_open = w_cur_open;
                end else if (w_cur_open != r_req) begin
                    // open or close: write back new state and record open time
                    w_we             = 1'b1;
                    w_waddr          = r_idx;
                    w_wdata.open     = r_req;
                    w_wdata.stamp    = r_req ? r_now : 32'd0;
                    n_valid[r_idx]   = 1'b1;
                    n_res.write_valid = 1'b1;
                    n_res.channel    = t_chan'(r_idx);
                    n_res.duty       = r_req ? FULL_DUTY : 8'd0;
                end
                n_state = ST_IDLE;
            end

            ST_CLEAR: begin
                // one zone per cycle: zero entry and send zero duty
                w_we                         = 1'b1;
                w_waddr                      = r_cnt[ZONE_W-1:0];
                w_wdata                      = '0;
                n_valid[r_cnt[ZONE_W-1:0]]   = 1'b0;
                n_res.strobe                 = 1'b1;
                n_res.ok                     = 1'b1;
                n_res.write_valid            = 1'b1;
                n_res.channel                = t_chan'(r_cnt[ZONE_W-1:0]);
                if (r_cnt == t_cnt'(ZONES - 1)) begin
                    n_res.last = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end

            ST_SCAN: begin
                // read of the next zone overlaps evaluation of the current one
                if (r_cnt < t_cnt'(ZONES - 1)) begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
                if (w_due) begin
                    // a due zone is held back until the next due zone or the flush, so the final word carries last
                    if (r_pend) begin
                        n_res.strobe      = 1'b1;
                        n_res.ok          = 1'b1;
                        n_res.write_valid = 1'b1;
                        n_res.channel     = t_chan'(r_pidx);
                        n_res.duty        = w_hold_duty;
                    end
                    n_pend = 1'b1;
                    n_pidx = r_evidx;
                end
                if (r_evidx == t_zidx'(ZONES - 1)) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_evidx = r_evidx + t_zidx'(1);
                end
            end

            ST_FLUSH: begin
                // last held word, or a bare ok when no zone was due
                n_res.strobe = 1'b1;
                n_res.ok     = 1'b1;
                n_res.last   = 1'b1;
                if (r_pend) begin
                    n_res.write_valid = 1'b1;
                    n_res.channel     = t_chan'(r_pidx);
                    n_res.duty        = w_hold_duty;
                end
                n_pend  = 1'b0;
                n_state = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_strobe      = r_res.strobe;
    assign o_ok          = r_res.ok;
    assign o_zone_open   = r_res.zone_open;
    assign o_write_valid = r_res.write_valid;
    assign o_channel     = r_res.channel;
    assign o_duty        = r_res.duty;
    assign o_last        = r_res.last;

endmodule

`default_nettype wire

FILE: test/vphd_duty_checker.sv
`timescale 1ns / 100ps
// predicts and checks the duty words of the valve peak-and-hold driver

module vphd_duty_checker
    import vphd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [3:0]  i_zone_id,
    input  wire logic        i_open_request,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_strobe,
    input  wire logic        i_ok,
    input  wire logic        i_zone_open,
    input  wire logic        i_write_valid,
    input  wire logic [2:0]  i_channel,
    input  wire logic [7:0]  i_duty,
    input  wire logic        i_last,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic       ok;
        logic       zone_open;
        logic       write_valid;
        t_chan      channel;
        logic [7:0] duty;
        logic       last;
    } t_duty_word;

    t_duty_word  duty_words_due[$];
    logic        valve_is_open [ZONES];
    logic [31:0] opened_at     [ZONES];
    logic [15:0] pull_in_q;
    logic [6:0]  hold_pct_q;

    function automatic t_duty_word make_word(input logic ok, input logic zopen,
                                             input logic wv, input t_chan ch,
                                             input logic [7:0] duty);
        t_duty_word w;
        w.ok          = ok;
        w.zone_open   = zopen;
        w.write_valid = wv;
        w.channel     = ch;
        w.duty        = duty;
        w.last        = 1'b0;
        return w;
    endfunction

    function automatic void predict_duty_words(input t_mode cmd, input logic [3:0] zid,
                                               input logic want_open,
                                               input logic [31:0] now);
        t_duty_word  batch[$];
        t_duty_word  w;
        int unsigned hold;
        int          slot;
        logic [31:0] elapsed;
        logic        zid_ok;
        zid_ok = (zid >= 4'd1) && (int'(zid) <= ZONES);
        slot   = int'(zid) - 1;
        case (cmd)
            MODE_SET: begin
                if (!zid_ok) begin
                    batch.push_back(make_word(1'b0, 1'b0, 1'b0, '0, '0));
                end else if (valve_is_open[slot] != want_open) begin
                    valve_is_open[slot] = want_open;
                    opened_at[slot]     = want_open ? now : 32'd0;
                    batch.push_back(make_word(1'b1, 1'b0, 1'b1, t_chan'(slot),
                                              want_open ? FULL_DUTY : 8'd0));
                end else begin
                    batch.push_back(make_word(1'b1, 1'b0, 1'b0, '0, '0));
                end
            end
            MODE_CLOSE: begin
                for (int i = 0; i < ZONES; i++) begin
                    valve_is_open[i] = 1'b0;
                    opened_at[i]     = 32'd0;
                    batch.push_back(make_word(1'b1, 1'b0, 1'b1, t_chan'(i), 8'd0));
                end
            end
            MODE_TICK: begin
                hold = int'(hold_pct_q) * int'(FULL_DUTY) / 100;
                if (hold > int'(FULL_DUTY))
                    hold = int'(FULL_DUTY);
                for (int i = 0; i < ZONES; i++) begin
                    elapsed = now - opened_at[i];
                    if (valve_is_open[i] && elapsed >= {16'd0, pull_in_q})
                        batch.push_back(make_word(1'b1, 1'b0, 1'b1, t_chan'(i), hold[7:0]));
                end
                if (batch.size() == 0)
                    batch.push_back(make_word(1'b1, 1'b0, 1'b0, '0, '0));
            end
            default: begin
                if (!zid_ok)
                    batch.push_back(make_word(1'b0, 1'b0, 1'b0, '0, '0));
                else
                    batch.push_back(make_word(1'b1, valve_is_open[slot], 1'b0, '0, '0));
            end
        endcase
        foreach (batch[i]) begin
            w      = batch[i];
            w.last = (i == batch.size() - 1);
            duty_words_due.push_back(w);
        end
    endfunction

    task automatic compare_field(input string fname, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: duty word field %s expected %0h actual %0h",
                     $time, fname, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_duty_word want;
        if (!i_rst_n) begin
            duty_words_due.delete();
            pull_in_q  = PULL_RESET;
            hold_pct_q = HOLD_RESET;
            for (int i = 0; i < ZONES; i++) begin
                valve_is_open[i] = 1'b0;
                opened_at[i]     = 32'd0;
            end
        end else begin
            if (i_strobe) begin
                if (duty_words_due.size() == 0) begin
                    $display({"%0t: duty word with none expected, expected none",
                              " actual ok=%0b ch=%0d duty=%0h"},
                             $time, i_ok, i_channel, i_duty);
                    o_fail_count++;
                end else begin
                    want = duty_words_due.pop_front();
                    compare_field("ok", want.ok, i_ok);
                    compare_field("zone_open", want.zone_open, i_zone_open);
                    compare_field("write_valid", want.write_valid, i_write_valid);
                    compare_field("channel", want.channel, i_channel);
                    compare_field("duty", want.duty, i_duty);
                    compare_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PULL_IN)
                    pull_in_q = i_cfg_data;
                else
                    hold_pct_q = i_cfg_data[6:0];
            end
            if (i_start && !i_busy)
                predict_duty_words(t_mode'(i_mode), i_zone_id, i_open_request, i_now_ms);
        end
        o_pending = duty_words_due.size();
    end

endmodule

FILE: test/tb_valve_peak_hold_driver.sv
`timescale 1ns / 100ps
// testbench top of the valve peak-and-hold driver: stimulus, config phases and verdict

module tb_valve_peak_hold_driver;
    import vphd_pkg::*;

    // quiet cycles before the watchdog gives up; far above the longest sender gap
    localparam int QUIET_LIMIT   = 1000;
    // linger after a drain, longer than a tick walk over all zones
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 48;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [3:0]  i_zone_id;
    logic        i_open_request;
    logic [31:0] i_now_ms;
    logic        o_strobe;
    logic        o_ok;
    logic        o_zone_open;
    logic        o_write_valid;
    logic [2:0]  o_channel;
    logic [7:0]  o_duty;
    logic        o_last;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    int          fail_count;
    int          pending;
    // millisecond clock that well-formed sequences follow
    logic [31:0] clock_ms;

    valve_peak_hold_driver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_zone_id      (i_zone_id),
        .i_open_request (i_open_request),
        .i_now_ms       (i_now_ms),
        .o_strobe       (o_strobe),
        .o_ok           (o_ok),
        .o_zone_open    (o_zone_open),
        .o_write_valid  (o_write_valid),
        .o_channel      (o_channel),
        .o_duty         (o_duty),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // watches the command, result and config ports, predicts the duty words and counts mismatches
    vphd_duty_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_zone_id      (i_zone_id),
        .i_open_request (i_open_request),
        .i_now_ms       (i_now_ms),
        .i_strobe       (o_strobe),
        .i_ok           (o_ok),
        .i_zone_open    (o_zone_open),
        .i_write_valid  (o_write_valid),
        .i_channel      (o_channel),
        .i_duty         (o_duty),
        .i_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // a cycle counts as quiet when no word, result or register write moves and reset is not held
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_valve_peak_hold_driver NOT OK");
        $finish;
    end

    // present one command word after a random gap, return once it is taken and busy is low
    task automatic issue_word(input int idle_pct, input t_mode cmd, input logic [3:0] zid,
                              input logic want_open, input logic [31:0] now);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            // junk on the fields while start is low must be ignored
            start          <= 1'b0;
            i_mode         <= 2'($urandom_range(3));
            i_zone_id      <= 4'($urandom_range(15));
            i_open_request <= 1'($urandom_range(1));
            i_now_ms       <= $urandom;
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_mode         <= cmd;
        i_zone_id      <= zid;
        i_open_request <= want_open;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // stop sending and wait until every expected word is back, then linger
    task automatic drain(input int extra);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly coherent traffic on a rising clock, with some noise mixed in
    task automatic run_phase(input int idle_pct, input int pull);
        int         pick;
        logic [3:0] zid;
        for (int n = 0; n < PHASE_WORDS; n++) begin
            // pressure: let the driver run dry once per phase
            if (n == PHASE_WORDS / 2)
                drain(0);
            pick = $urandom_range(99);
            if (pick < 45) begin
                if ($urandom_range(9) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, pull / 2 + 40);
                issue_word(idle_pct, MODE_TICK, 4'($urandom_range(15)),
                           1'($urandom_range(1)), clock_ms);
            end else if (pick < 80) begin
                if ($urandom_range(9) == 0)
                    zid = ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(ZONES + 1, 15));
                else
                    zid = 4'($urandom_range(1, ZONES));
                issue_word(idle_pct, MODE_SET, zid, ($urandom_range(99) < 65), clock_ms);
            end else if (pick < 88) begin
                issue_word(idle_pct, MODE_CLOSE, 4'($urandom_range(15)),
                           1'($urandom_range(1)), $urandom);
            end else begin
                issue_word(idle_pct, MODE_QUERY, 4'($urandom_range(15)),
                           1'($urandom_range(1)), $urandom);
            end
        end
    endtask

    initial begin
        int          pull;
        logic [15:0] hold_data;
        start          = 1'b0;
        i_mode         = MODE_SET;
        i_zone_id      = 4'd0;
        i_open_request = 1'b0;
        i_now_ms       = 32'd0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_PULL_IN;
        i_cfg_data     = 16'd0;
        i_rst_n        = 1'b0;
        clock_ms       = 32'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the reset settings: pull-in 200 ms, hold 50 percent
        issue_word(0, MODE_QUERY, 4'd1, 1'b0, 32'd0);            // closed zone
        issue_word(0, MODE_TICK, 4'd0, 1'b0, 32'd0);             // nothing due
        issue_word(0, MODE_SET, 4'd0, 1'b1, 32'd5);              // zone zero is invalid
        issue_word(0, MODE_SET, 4'd7, 1'b1, 32'd5);              // one past the last zone
        issue_word(0, MODE_QUERY, 4'd15, 1'b0, 32'd0);
        issue_word(0, MODE_QUERY, 4'd0, 1'b1, 32'd0);
        issue_word(0, MODE_SET, 4'd1, 1'b1, 32'd0);              // opened at time zero
        issue_word(0, MODE_SET, 4'd1, 1'b1, 32'd50);             // no change, no write
        issue_word(0, MODE_QUERY, 4'd1, 1'b0, 32'd0);
        issue_word(0, MODE_TICK, 4'd0, 1'b0, 32'd199);           // one short of pull-in
        issue_word(0, MODE_TICK, 4'd0, 1'b0, 32'd200);           // exactly at pull-in
        issue_word(0, MODE_SET, 4'd6, 1'b1, 32'hFFFF_FFF0);
        issue_word(0, MODE_TICK, 4'd0, 1'b0, 32'h0000_0100);     // elapsed wraps past zero
        for (int z = 2; z <= 5; z++)
            issue_word(0, MODE_SET, 4'(z), 1'b1, 32'd300);
        issue_word(0, MODE_TICK, 4'd0, 1'b0, 32'd600);           // every zone holds
        issue_word(0, MODE_SET, 4'd2, 1'b0, 32'd610);
        issue_word(0, MODE_SET, 4'd2, 1'b0, 32'd620);            // already closed
        issue_word(0, MODE_CLOSE, 4'd9, 1'b1, 32'hFFFF_FFFF);
        issue_word(0, MODE_QUERY, 4'd3, 1'b0, 32'd0);
        issue_word(0, MODE_SET, 4'd3, 1'b1, 32'hFFFF_FFFF);
        issue_word(0, MODE_TICK, 4'd0, 1'b0, 32'h0000_00C7);     // 200 ms across the wrap
        issue_word(0, MODE_CLOSE, 4'd0, 1'b0, 32'd0);

        // config phases: extremes first, then odd and random settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin pull = 0;     hold_data = 16'd100;  end
                1: begin pull = 65535; hold_data = 16'd0;    end
                2: begin pull = $urandom_range(1, 400); hold_data = 16'hFFFF; end  // hold saturates
                3: begin pull = 200;   hold_data = 16'd37;   end
                default: begin
                    pull      = $urandom_range(0, 65535);
                    hold_data = 16'($urandom_range(0, 65535));
                end
            endcase
            drain(SETTLE_CYCLES);
            write_reg(CFG_PULL_IN, 16'(pull));
            write_reg(CFG_HOLD, hold_data);
            case (ph)
                1, 4:    run_phase(77, pull);
                3:       run_phase(19, pull);
                default: run_phase(0, pull);
            endcase
        end

        drain(20);
        if (fail_count == 0 && pending == 0)
            $display("tb_valve_peak_hold_driver OK");
        else
            $display("tb_valve_peak_hold_driver NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/vphd_pkg.sv
src/vphd_ram.sv
src/vphd_hold.sv
src/valve_peak_hold_driver.sv
test/vphd_duty_checker.sv
test/tb_valve_peak_hold_driver.sv
